// ===== design/ipv6_neighbor_cache_macros.svh =====
// Assertion macros for the IPv6 neighbor cache.
// Used at the end of the top level; they expect clk_i and rst_ni in scope.
`ifndef IPV6_NEIGHBOR_CACHE_MACROS_SVH
`define IPV6_NEIGHBOR_CACHE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ipv6nc_pkg.sv =====
// Shared types and constants for the IPv6 neighbor cache.
// No dependencies; imported by every module of the block but ipv6nc_ram.
`timescale 1ns / 1ps

package ipv6nc_pkg;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned SLOT_W = 4;
  // One table word: key high, key low, then the link-layer address.
  localparam int unsigned ENT_W  = 2 * KEY_W + MAC_W;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_PUT    = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    STAT_HIT      = 3'd0,
    STAT_MISS     = 3'd1,
    STAT_UPDATED  = 3'd2,
    STAT_INSERTED = 3'd3,
    STAT_FULL     = 3'd4,
    STAT_CLEARED  = 3'd5
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    status_e             status;
    logic [MAC_W-1:0]    mac_out;
    logic [SLOT_W-1:0]   slot;
  } res_t;

endpackage

// ===== design/ipv6nc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ipv6nc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                           clk_i,
  input  logic                                           we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]                               wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr_i,
  output logic [WIDTH-1:0]                               rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/ipv6nc_cmp.sv =====
// Shared key compare unit: matches the requested address against one table word.
// Depends on ipv6nc_pkg.
`timescale 1ns / 1ps

module ipv6nc_cmp (
  input  logic [ipv6nc_pkg::KEY_W-1:0] key_hi_i,
  input  logic [ipv6nc_pkg::KEY_W-1:0] key_lo_i,
  input  logic [ipv6nc_pkg::ENT_W-1:0] ent_i,
  input  logic                         ent_valid_i,
  output logic                         match_o
);

  import ipv6nc_pkg::*;

  logic [KEY_W-1:0] ent_hi;
  logic [KEY_W-1:0] ent_lo;

  assign ent_hi = ent_i[ENT_W-1 -: KEY_W];
  assign ent_lo = ent_i[MAC_W +: KEY_W];

  // An entry only matches while its valid bit is set.
  assign match_o = ent_valid_i && (ent_hi == key_hi_i) && (ent_lo == key_lo_i);

endmodule

// ===== design/ipv6nc_ctrl.sv =====
// Scan sequencer: walks the table one entry per cycle, keeps the valid bits,
// tracks the lowest free entry and forms the result beat. Depends on ipv6nc_pkg.
`timescale 1ns / 1ps

module ipv6nc_ctrl #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IW      = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  ipv6nc_pkg::op_e               op_i,
  input  logic                          match_i,
  input  logic [ipv6nc_pkg::MAC_W-1:0]  rd_mac_i,
  output logic                          busy_o,
  output logic                          accept_o,
  output logic [IW-1:0]                 raddr_o,
  output logic                          ent_valid_o,
  output logic                          we_o,
  output logic [IW-1:0]                 waddr_o,
  output ipv6nc_pkg::res_t              res_o,
  output logic                          done_o
);

  import ipv6nc_pkg::*;

  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic                 issue_q, issue_d;
  logic                 chk_q, chk_d;
  logic [IW-1:0]        chk_idx_q, chk_idx_d;
  logic                 free_found_q, free_found_d;
  logic [IW-1:0]        free_idx_q, free_idx_d;
  logic [ENTRIES-1:0]   valid_q, valid_d;
  res_t                 res_q, res_d;
  logic                 done_q, done_d;
  logic                 scan_end;

  assign busy_o      = (state_q != ST_IDLE);
  assign accept_o    = start_i && !busy_o;
  assign raddr_o     = idx_q;
  assign ent_valid_o = valid_q[chk_idx_q];
  assign res_o       = res_q;
  assign done_o      = done_q;

  // The scan ends on the first match or after the last entry was checked.
  assign scan_end = chk_q && (match_i || (chk_idx_q == LAST));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_o && (op_i != OP_CLEAR)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    op_d         = op_q;
    idx_d        = idx_q;
    issue_d      = issue_q;
    chk_d        = 1'b0;
    chk_idx_d    = chk_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    valid_d      = valid_q;
    res_d        = res_q;
    done_d       = 1'b0;
    we_o         = 1'b0;
    waddr_o      = chk_idx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_o) begin
          op_d         = op_i;
          idx_d        = '0;
          issue_d      = 1'b1;
          free_found_d = 1'b0;
          // A clear needs no scan: drop every valid bit and answer at once.
          if (op_i == OP_CLEAR) begin
            valid_d       = '0;
            res_d.status  = STAT_CLEARED;
            res_d.mac_out = '0;
            res_d.slot    = '0;
            done_d        = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        // Issue stage: read address goes out, free entries are noted here.
        chk_d     = issue_q;
        chk_idx_d = idx_q;
        if (issue_q) begin
          if (!valid_q[idx_q] && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = idx_q;
          end
          if (idx_q == LAST) begin
            issue_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        // Check stage: read data of the previous address is compared.
        if (chk_q) begin
          if (match_i) begin
            done_d     = 1'b1;
            res_d.slot = SLOT_W'(chk_idx_q);
            if (op_q == OP_PUT) begin
              we_o          = 1'b1;
              waddr_o       = chk_idx_q;
              res_d.status  = STAT_UPDATED;
              res_d.mac_out = '0;
            end else begin
              res_d.status  = STAT_HIT;
              res_d.mac_out = rd_mac_i;
            end
          end else if (chk_idx_q == LAST) begin
            done_d        = 1'b1;
            res_d.mac_out = '0;
            res_d.slot    = '0;
            if (op_q == OP_PUT) begin
              if (free_found_q) begin
                we_o                = 1'b1;
                waddr_o             = free_idx_q;
                valid_d[free_idx_q] = 1'b1;
                res_d.status        = STAT_INSERTED;
                res_d.slot          = SLOT_W'(free_idx_q);
              end else begin
                res_d.status = STAT_FULL;
              end
            end else begin
              res_d.status = STAT_MISS;
            end
          end
        end
      end
      default: begin
        issue_d = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      issue_q      <= 1'b0;
      chk_q        <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      issue_q      <= issue_d;
      chk_q        <= chk_d;
      free_found_q <= free_found_d;
      valid_q      <= valid_d;
      done_q       <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    idx_q      <= idx_d;
    chk_idx_q  <= chk_idx_d;
    free_idx_q <= free_idx_d;
    res_q      <= res_d;
  end

endmodule

// ===== design/ipv6_neighbor_cache.sv =====
// Top level of the IPv6 neighbor cache: request latch, table RAM, compare unit
// and scan sequencer. Depends on ipv6nc_pkg, ipv6nc_ram, ipv6nc_cmp, ipv6nc_ctrl.
//
//   channel   handshake          payload
//   request   start_i / busy_o   op_i, addr_high_i, addr_low_i, mac_in_i
//   result    done_o             status_o, mac_out_o, slot_o
//
// A lookup or put walks the table from entry 0, reading an entry in the issue stage
// and comparing it in the check stage; the result is registered on the first match
// or after the last entry. The RAM read port scans one entry per cycle. A clear
// answers in the cycle after accept. Reset leaves every entry invalid; no clearing
// pass is needed. The result beat lasts one cycle and cannot be stalled; busy_o is
// low again in the cycle that done_o is high, so the next request may enter then.
`timescale 1ns / 1ps
`include "ipv6_neighbor_cache_macros.svh"

module ipv6_neighbor_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    op_i,
  input  logic [ipv6nc_pkg::KEY_W-1:0]  addr_high_i,
  input  logic [ipv6nc_pkg::KEY_W-1:0]  addr_low_i,
  input  logic [ipv6nc_pkg::MAC_W-1:0]  mac_in_i,
  output logic                          done_o,
  output logic [2:0]                    status_o,
  output logic [ipv6nc_pkg::MAC_W-1:0]  mac_out_o,
  output logic [ipv6nc_pkg::SLOT_W-1:0] slot_o
);

  import ipv6nc_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [KEY_W-1:0] key_hi_q;
  logic [KEY_W-1:0] key_lo_q;
  logic [MAC_W-1:0] mac_q;
  logic             accept;
  logic [IW-1:0]    raddr;
  logic [IW-1:0]    waddr;
  logic             ram_we;
  logic [ENT_W-1:0] rdata;
  logic             ent_valid;
  logic             match;
  res_t             res;

  // Request latch; the payload is held for the whole scan.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_hi_q <= addr_high_i;
      key_lo_q <= addr_low_i;
      mac_q    <= mac_in_i;
    end
  end

  // Table storage: key and link-layer address of each entry.
  ipv6nc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i ({key_hi_q, key_lo_q, mac_q}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Shared key compare.
  ipv6nc_cmp u_cmp (
    .key_hi_i    (key_hi_q),
    .key_lo_i    (key_lo_q),
    .ent_i       (rdata),
    .ent_valid_i (ent_valid),
    .match_o     (match)
  );

  // Scan sequencer.
  ipv6nc_ctrl #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .op_i        (op_e'(op_i)),
    .match_i     (match),
    .rd_mac_i    (rdata[MAC_W-1:0]),
    .busy_o      (busy_o),
    .accept_o    (accept),
    .raddr_o     (raddr),
    .ent_valid_o (ent_valid),
    .we_o        (ram_we),
    .waddr_o     (waddr),
    .res_o       (res),
    .done_o      (done_o)
  );

  assign status_o  = res.status;
  assign mac_out_o = res.mac_out;
  assign slot_o    = res.slot;

  // A lookup or put keeps the block busy after it is accepted.
  `NC_ASSERT_NEXT(a_scan_busy, accept && (op_i != OP_CLEAR), busy_o, "scan did not start")
  // Only a hit carries a link-layer address.
  `NC_ASSERT_NOW(a_mac_zero, done_o && (status_o != STAT_HIT), mac_out_o == '0, "stray mac")
  // The table is written only at the end of a scan.
  `NC_ASSERT_NOW(a_we_scan, ram_we, busy_o && !done_o, "table write outside scan")

endmodule
